[sv/spa_pkg.sv]
`timescale 1ns / 1ps
// spa_pkg: shared types, codes and constants of the segregated pool allocator.
// No dependencies.

package spa_pkg;

    localparam int HEAP_CHUNKS_DEF = 64;
    localparam int NUM_CLASSES     = 8;
    localparam int CLS_W           = 3;
    localparam int HDR_W           = 4;
    localparam int STAT_W          = 3;
    localparam int ADDR_W          = 18;
    localparam int ADDR_SLOT_W     = 13;
    localparam int CHUNK_SLOT_W    = 7;
    localparam int SLOTS_PER_CHUNK = 128;
    localparam int SLOT_BYTES      = 32;
    localparam int HDR_BYTES       = 8;
    localparam int NEED_W          = 13;
    localparam int REQ_W           = 32;
    localparam int CHUNK_OFF_W     = 6;

    localparam logic [REQ_W-1:0]  MAX_REQ   = 32'd4088;
    localparam logic [CLS_W-1:0]  TOP_CLASS = 3'd7;
    localparam logic [CLS_W-1:0]  PUSH_TOP  = 3'd6;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEM    = 3'd3,
        ST_FREE_IGN  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_FREE,
        S_REFILL
    } t_state;

    typedef struct packed {
        logic             zero;
        logic             too_big;
        logic [CLS_W-1:0] cls;
    } t_size_info;

    typedef struct packed {
        logic             hdr_we;
        logic             link_we;
        logic [HDR_W-1:0] hdr_wdata;
    } t_mem_ctl;

endpackage

[sv/spa_size_class.sv]
`timescale 1ns / 1ps
// spa_size_class: request size checks and size class selection.
// Depends on spa_pkg.

module spa_size_class (
    input  logic [spa_pkg::REQ_W-1:0] i_req_size,
    output spa_pkg::t_size_info       o_info
);

    localparam int NW = spa_pkg::NEED_W;

    logic [NW-1:0] round_up;
    logic [NW-1:0] need;

    always_comb begin
        round_up = i_req_size[NW-1:0] + NW'(7);
        need     = {round_up[NW-1:3], 3'b000} + NW'(spa_pkg::HDR_BYTES);
        o_info.zero    = (i_req_size == '0);
        o_info.too_big = (i_req_size > spa_pkg::MAX_REQ);
        o_info.cls     = spa_pkg::TOP_CLASS;
        for (int c = spa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
            if (need <= (NW'(spa_pkg::SLOT_BYTES) << c)) begin
                o_info.cls = spa_pkg::CLS_W'(c);
            end
        end
    end

endmodule

[sv/spa_slot_mem.sv]
`timescale 1ns / 1ps
// spa_slot_mem: per-slot link and header memories, one shared address, registered reads.
// Depends on spa_pkg.

module spa_slot_mem #(
    parameter int SLOT_W = 13,
    parameter int DEPTH  = 8192
) (
    input  logic                        i_clk,
    input  logic [SLOT_W-1:0]           i_addr,
    input  spa_pkg::t_mem_ctl           i_ctl,
    input  logic [SLOT_W-1:0]           i_link_wdata,
    output logic [spa_pkg::HDR_W-1:0]   o_hdr_rdata,
    output logic [SLOT_W-1:0]           o_link_rdata
);

    logic [SLOT_W-1:0]         r_link [DEPTH];
    logic [spa_pkg::HDR_W-1:0] r_hdr  [DEPTH];
    logic [SLOT_W-1:0]         r_link_rd;
    logic [spa_pkg::HDR_W-1:0] r_hdr_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link[i_addr] <= i_link_wdata;
        end
        r_link_rd <= r_link[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.hdr_we) begin
            r_hdr[i_addr] <= i_ctl.hdr_wdata;
        end
        r_hdr_rd <= r_hdr[i_addr];
    end

    assign o_hdr_rdata  = r_hdr_rd;
    assign o_link_rdata = r_link_rd;

endmodule

[sv/segregated_pool_allocator_unit.sv]
`timescale 1ns / 1ps
// Allocator top (sequencer, list heads, chunk count); uses spa_pkg, spa_size_class, spa_slot_mem.
// Rejects are answered from the decode state, a pop or a free through S_POP or S_FREE,
// and a chunk take from decode (top class) or after S_REFILL (one push into the slot memory per cycle).
// A new request is taken only in S_IDLE; busy covers the whole request.
// Reset (synchronous, active low) empties all lists and clears the chunk count.
// Results are never stalled; o_valid marks each one for a single cycle.

module segregated_pool_allocator_unit #(
    parameter int HEAP_CHUNKS = spa_pkg::HEAP_CHUNKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [spa_pkg::REQ_W-1:0]     i_req_size,
    input  logic [spa_pkg::ADDR_W-1:0]    i_free_addr,
    output logic                          o_valid,
    output logic [spa_pkg::ADDR_W-1:0]    o_data_addr,
    output logic [spa_pkg::CLS_W-1:0]     o_granted_class,
    output logic [spa_pkg::STAT_W-1:0]    o_status
);

    localparam int TOTAL_SLOTS = HEAP_CHUNKS * spa_pkg::SLOTS_PER_CHUNK;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
    localparam int CHUNK_W     = $clog2(HEAP_CHUNKS + 1);
    localparam int CMP_W       = (CHUNK_W > spa_pkg::CHUNK_OFF_W) ? CHUNK_W
                                                                  : spa_pkg::CHUNK_OFF_W;
    localparam int NC          = spa_pkg::NUM_CLASSES;
    localparam int CW          = spa_pkg::CLS_W;
    localparam int AW          = spa_pkg::ADDR_W;
    localparam int ASW         = spa_pkg::ADDR_SLOT_W;
    localparam int OW          = spa_pkg::CHUNK_SLOT_W;

    spa_pkg::t_state              r_state, n_state;
    logic                         r_kind, n_kind;
    logic [spa_pkg::REQ_W-1:0]    r_req, n_req;
    logic [AW-1:0]                r_addr, n_addr;
    logic [CW-1:0]                r_cls, n_cls;
    logic [CW-1:0]                r_i, n_i;
    logic [SLOT_W-1:0]            r_slot, n_slot;
    logic [SLOT_W-1:0]            r_base, n_base;
    logic [OW-1:0]                r_off, n_off;
    logic [CHUNK_W-1:0]           r_chunks, n_chunks;
    logic [NC-1:0]                r_head_vld, n_head_vld;
    logic [SLOT_W-1:0]            r_head_slot [NC];
    logic [SLOT_W-1:0]            n_head_slot [NC];
    logic                         r_valid, n_valid;
    logic [AW-1:0]                r_data_addr, n_data_addr;
    logic [CW-1:0]                r_gcls, n_gcls;
    logic [spa_pkg::STAT_W-1:0]   r_status, n_status;

    spa_pkg::t_size_info          size_info;
    spa_pkg::t_mem_ctl            mem_ctl;
    logic [SLOT_W-1:0]            mem_addr;
    logic [SLOT_W-1:0]            link_wdata;
    logic [spa_pkg::HDR_W-1:0]    hdr_rd;
    logic [SLOT_W-1:0]            link_rd;

    logic                         hit;
    logic [CW-1:0]                hit_idx;
    logic [CW-1:0]                h_sel;
    logic                         h_vld;
    logic [SLOT_W-1:0]            h_slot;
    logic [AW-1:0]                free_off;
    logic                         free_bad;
    logic [SLOT_W-1:0]            free_slot;
    logic [SLOT_W-1:0]            fresh_base;
    logic [SLOT_W-1:0]            push_slot;
    logic                         chunks_full;

    spa_size_class u_size_class (
        .i_req_size (r_req),
        .o_info     (size_info)
    );

    spa_slot_mem #(
        .SLOT_W (SLOT_W),
        .DEPTH  (TOTAL_SLOTS)
    ) u_slot_mem (
        .i_clk        (i_clk),
        .i_addr       (mem_addr),
        .i_ctl        (mem_ctl),
        .i_link_wdata (link_wdata),
        .o_hdr_rdata  (hdr_rd),
        .o_link_rdata (link_rd)
    );

    // first non-empty list at or above the requested class
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int c = NC - 1; c >= 0; c--) begin
            if ((CW'(c) >= size_info.cls) && r_head_vld[c]) begin
                hit     = 1'b1;
                hit_idx = CW'(c);
            end
        end
    end

    always_comb begin
        free_off    = r_addr - AW'(spa_pkg::HDR_BYTES);
        free_slot   = SLOT_W'(free_off[AW-1:5]);
        free_bad    = (r_addr < AW'(spa_pkg::HDR_BYTES)) || (free_off[4:0] != 5'd0) ||
                      (CMP_W'(free_off[AW-1:12]) >= CMP_W'(r_chunks));
        fresh_base  = SLOT_W'({r_chunks, {OW{1'b0}}});
        push_slot   = r_base + SLOT_W'(r_off);
        chunks_full = (r_chunks >= CHUNK_W'(HEAP_CHUNKS));
    end

    // single read port on the list heads
    always_comb begin
        unique case (r_state)
            spa_pkg::S_POP:    h_sel = r_cls;
            spa_pkg::S_FREE:   h_sel = hdr_rd[CW-1:0];
            spa_pkg::S_REFILL: h_sel = r_i;
            default:           h_sel = hit_idx;
        endcase
        h_vld  = r_head_vld[h_sel];
        h_slot = r_head_slot[h_sel];
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_req       = r_req;
        n_addr      = r_addr;
        n_cls       = r_cls;
        n_i         = r_i;
        n_slot      = r_slot;
        n_base      = r_base;
        n_off       = r_off;
        n_chunks    = r_chunks;
        n_head_vld  = r_head_vld;
        n_head_slot = r_head_slot;
        n_valid     = 1'b0;
        n_data_addr = '0;
        n_gcls      = '0;
        n_status    = spa_pkg::ST_OK;
        mem_ctl     = '0;
        mem_addr    = r_slot;
        link_wdata  = r_slot;

        unique case (r_state)
            spa_pkg::S_IDLE: begin
                if (start) begin
                    n_state = spa_pkg::S_DECODE;
                    n_kind  = i_kind;
                    n_req   = i_req_size;
                    n_addr  = i_free_addr;
                end
            end
            spa_pkg::S_DECODE: begin
                if (r_kind == spa_pkg::KIND_ALLOC) begin
                    if (size_info.zero) begin
                        n_state  = spa_pkg::S_IDLE;
                        n_valid  = 1'b1;
                        n_status = spa_pkg::ST_ZERO;
                    end else if (size_info.too_big) begin
                        n_state  = spa_pkg::S_IDLE;
                        n_valid  = 1'b1;
                        n_status = spa_pkg::ST_TOO_LARGE;
                    end else if (hit) begin
                        mem_addr = h_slot;
                        n_slot   = h_slot;
                        n_cls    = hit_idx;
                        n_state  = spa_pkg::S_POP;
                    end else if (chunks_full) begin
                        n_state  = spa_pkg::S_IDLE;
                        n_valid  = 1'b1;
                        n_status = spa_pkg::ST_NO_MEM;
                    end else begin
                        mem_addr          = fresh_base;
                        mem_ctl.hdr_we    = 1'b1;
                        mem_ctl.hdr_wdata = {1'b1, size_info.cls};
                        n_chunks          = r_chunks + CHUNK_W'(1);
                        n_base            = fresh_base;
                        n_cls             = size_info.cls;
                        n_off             = OW'(1) << size_info.cls;
                        n_i               = spa_pkg::PUSH_TOP;
                        if (size_info.cls == spa_pkg::TOP_CLASS) begin
                            n_state     = spa_pkg::S_IDLE;
                            n_valid     = 1'b1;
                            n_data_addr = {ASW'(fresh_base), 5'd8};
                            n_gcls      = size_info.cls;
                        end else begin
                            n_state = spa_pkg::S_REFILL;
                        end
                    end
                end else begin
                    if (free_bad) begin
                        n_state  = spa_pkg::S_IDLE;
                        n_valid  = 1'b1;
                        n_status = spa_pkg::ST_FREE_IGN;
                    end else begin
                        mem_addr = free_slot;
                        n_slot   = free_slot;
                        n_state  = spa_pkg::S_FREE;
                    end
                end
            end
            spa_pkg::S_POP: begin
                mem_ctl.hdr_we     = 1'b1;
                mem_ctl.hdr_wdata  = {1'b1, r_cls};
                n_head_vld[r_cls]  = (link_rd != r_slot);
                n_head_slot[r_cls] = link_rd;
                n_state            = spa_pkg::S_IDLE;
                n_valid            = 1'b1;
                n_data_addr        = {ASW'(r_slot), 5'd8};
                n_gcls             = r_cls;
            end
            spa_pkg::S_FREE: begin
                n_state = spa_pkg::S_IDLE;
                n_valid = 1'b1;
                if (!hdr_rd[spa_pkg::HDR_W-1]) begin
                    n_status = spa_pkg::ST_FREE_IGN;
                end else begin
                    mem_ctl.hdr_we     = 1'b1;
                    mem_ctl.link_we    = 1'b1;
                    mem_ctl.hdr_wdata  = {1'b0, hdr_rd[CW-1:0]};
                    link_wdata         = h_vld ? h_slot : r_slot;
                    n_head_vld[h_sel]  = 1'b1;
                    n_head_slot[h_sel] = r_slot;
                end
            end
            spa_pkg::S_REFILL: begin
                mem_addr          = push_slot;
                mem_ctl.hdr_we    = 1'b1;
                mem_ctl.link_we   = 1'b1;
                mem_ctl.hdr_wdata = {1'b0, r_i};
                link_wdata        = h_vld ? h_slot : push_slot;
                n_head_vld[r_i]   = 1'b1;
                n_head_slot[r_i]  = push_slot;
                n_off             = r_off + (OW'(1) << r_i);
                n_i               = r_i - CW'(1);
                if (r_i == r_cls) begin
                    n_state     = spa_pkg::S_IDLE;
                    n_valid     = 1'b1;
                    n_data_addr = {ASW'(r_base), 5'd8};
                    n_gcls      = r_cls;
                end
            end
            default: begin
                n_state = spa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spa_pkg::S_IDLE;
            r_chunks   <= '0;
            r_head_vld <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_chunks   <= n_chunks;
            r_head_vld <= n_head_vld;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_req       <= n_req;
        r_addr      <= n_addr;
        r_cls       <= n_cls;
        r_i         <= n_i;
        r_slot      <= n_slot;
        r_base      <= n_base;
        r_off       <= n_off;
        r_head_slot <= n_head_slot;
        r_data_addr <= n_data_addr;
        r_gcls      <= n_gcls;
        r_status    <= n_status;
    end

    assign busy            = (r_state != spa_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_data_addr     = r_data_addr;
    assign o_granted_class = r_gcls;
    assign o_status        = r_status;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunks <= CHUNK_W'(HEAP_CHUNKS))
        else $error("chunk count beyond heap");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != spa_pkg::ST_OK))
            |-> (o_data_addr == '0 && o_granted_class == '0))
        else $error("rejected request carries an address");

    a_refill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spa_pkg::S_DECODE && n_state == spa_pkg::S_REFILL)
            |=> (r_chunks == $past(r_chunks) + CHUNK_W'(1)))
        else $error("refill without chunk take");

endmodule

[tb/sv/segregated_pool_allocator_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for segregated_pool_allocator_unit: directed table, then random
// allocate/free traffic checked against an in-bench model of the free lists and chunk usage.
// Depends on spa_pkg and segregated_pool_allocator_unit.

module segregated_pool_allocator_unit_tb;

    import spa_pkg::*;

    localparam int CHUNK_BYTES   = SLOTS_PER_CHUNK * SLOT_BYTES;
    localparam int TOTAL_SLOTS   = HEAP_CHUNKS_DEF * SLOTS_PER_CHUNK;
    localparam int HDR_ALLOC_BIT = 3;
    localparam int N_DIRECTED    = 25;
    localparam int N_SEGMENTS    = 11;
    localparam int SEG_ITEMS     = 50;
    localparam int ALLOC_PCT [N_SEGMENTS] = '{70, 95, 30, 80, 20, 75, 90, 25, 60, 85, 40};

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CLS_W-1:0]  cls;
        t_status           st;
    } reply_t;

    typedef struct packed {
        logic              kind;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        reply_t            want;
    } req_row_t;

    localparam reply_t NONE = '{18'd0, 3'd0, ST_OK};

    // typed rows carry a fixed expected reply, which also depends on the heap state left by earlier rows
    localparam req_row_t DIRECTED [N_DIRECTED] = '{
        '{KIND_ALLOC, 32'd0,          18'd0,      1'b1, '{18'd0, 3'd0, ST_ZERO}},
        '{KIND_ALLOC, 32'hFFFF_FFFF,  18'd0,      1'b1, '{18'd0, 3'd0, ST_TOO_LARGE}},
        '{KIND_ALLOC, 32'd4089,       18'h3FFFF,  1'b1, '{18'd0, 3'd0, ST_TOO_LARGE}},
        '{KIND_FREE,  32'hFFFF_FFFF,  18'd0,      1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_FREE,  32'd0,          18'd8,      1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_ALLOC, 32'd1,          18'd0,      1'b1, '{18'd8, 3'd0, ST_OK}},
        '{KIND_ALLOC, 32'd24,         18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd25,         18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd4088,       18'd0,      1'b1, '{18'd4104, 3'd7, ST_OK}},
        '{KIND_FREE,  32'd0,          18'd4104,   1'b1, '{18'd0, 3'd0, ST_OK}},
        '{KIND_FREE,  32'd0,          18'd4104,   1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_FREE,  32'd0,          18'd9,      1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_FREE,  32'd0,          18'd7,      1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_FREE,  32'd0,          18'd8,      1'b1, '{18'd0, 3'd0, ST_OK}},
        '{KIND_FREE,  32'd0,          18'd8200,   1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_FREE,  32'd0,          18'h3FFFF,  1'b1, '{18'd0, 3'd0, ST_FREE_IGN}},
        '{KIND_ALLOC, 32'd4088,       18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd2041,       18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd2040,       18'd0,      1'b0, NONE},
        '{KIND_FREE,  32'hFFFF_FFFF,  18'd40,     1'b0, NONE},
        '{KIND_ALLOC, 32'd8,          18'h3FFFF,  1'b0, NONE},
        '{KIND_ALLOC, 32'd500,        18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd248,        18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd120,        18'd0,      1'b0, NONE},
        '{KIND_ALLOC, 32'd1000,       18'd0,      1'b0, NONE}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_kind = KIND_ALLOC;
    logic [REQ_W-1:0]    i_req_size = '0;
    logic [ADDR_W-1:0]   i_free_addr = '0;
    logic                o_valid;
    logic [ADDR_W-1:0]   o_data_addr;
    logic [CLS_W-1:0]    o_granted_class;
    logic [STAT_W-1:0]   o_status;

    // model of the pool
    logic [13:0]       list_head [NUM_CLASSES] = '{default: '0};
    logic [12:0]       next_slot [TOTAL_SLOTS];
    bit   [HDR_W-1:0]  blk_hdr   [TOTAL_SLOTS];
    bit                hdr_known [TOTAL_SLOTS];
    int                chunks_taken = 0;
    int                live_slots [$];
    int                block_starts [$];

    reply_t            pending_replies [$];
    int                mismatch_cnt = 0;

    segregated_pool_allocator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_req_size      (i_req_size),
        .i_free_addr     (i_free_addr),
        .o_valid         (o_valid),
        .o_data_addr     (o_data_addr),
        .o_granted_class (o_granted_class),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic void set_header(int slot, logic [HDR_W-1:0] value);
        blk_hdr[slot] = value;
        if (!hdr_known[slot]) begin
            hdr_known[slot] = 1'b1;
            block_starts.push_back(slot);
        end
    endfunction

    function automatic void push_free_block(int slot, int cls);
        if (list_head[cls][13]) begin
            next_slot[slot] = list_head[cls][12:0];
        end else begin
            next_slot[slot] = 13'(slot);
        end
        list_head[cls] = {1'b1, 13'(slot)};
    endfunction

    function automatic reply_t predict_reply(logic kind, logic [REQ_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
        reply_t        rep;
        logic [32:0]   usable;
        int            cls, i, j, slot, base, off, a;
        bit            found;
        rep = NONE;
        if (kind == KIND_ALLOC) begin
            usable = ({1'b0, size} + 33'd7) & ~33'd7;
            if (size == '0) begin
                rep.st = ST_ZERO;
            end else if (usable > MAX_REQ) begin
                rep.st = ST_TOO_LARGE;
            end else begin
                cls = 0;
                while (cls < TOP_CLASS && (SLOT_BYTES << cls) < usable + HDR_BYTES) cls++;
                found = 1'b0;
                for (i = cls; i < NUM_CLASSES && !found; i++) begin
                    if (list_head[i][13]) begin
                        slot = list_head[i][12:0];
                        list_head[i] = (next_slot[slot] == slot) ? '0
                                                                 : {1'b1, next_slot[slot]};
                        set_header(slot, {1'b1, 3'(i)});
                        live_slots.push_back(slot);
                        rep = '{18'(slot * SLOT_BYTES + HDR_BYTES), 3'(i), ST_OK};
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    if (chunks_taken >= HEAP_CHUNKS_DEF) begin
                        rep.st = ST_NO_MEM;
                    end else begin
                        base = chunks_taken * SLOTS_PER_CHUNK;
                        chunks_taken++;
                        set_header(base, {1'b1, 3'(cls)});
                        off = SLOT_BYTES << cls;
                        for (i = PUSH_TOP; i >= 0; i--) begin
                            if (CHUNK_BYTES - off >= (SLOT_BYTES << i) && i >= cls) begin
                                slot = base + off / SLOT_BYTES;
                                set_header(slot, {1'b0, 3'(i)});
                                push_free_block(slot, i);
                                off += SLOT_BYTES << i;
                            end
                        end
                        live_slots.push_back(base);
                        rep = '{18'(base * SLOT_BYTES + HDR_BYTES), 3'(cls), ST_OK};
                    end
                end
            end
        end else begin
            a = addr;
            rep.st = ST_FREE_IGN;
            if (a >= HDR_BYTES && (a - HDR_BYTES) % SLOT_BYTES == 0) begin
                slot = (a - HDR_BYTES) / SLOT_BYTES;
                if (slot < chunks_taken * SLOTS_PER_CHUNK && blk_hdr[slot][HDR_ALLOC_BIT]) begin
                    blk_hdr[slot][HDR_ALLOC_BIT] = 1'b0;
                    push_free_block(slot, blk_hdr[slot][2:0]);
                    for (j = 0; j < live_slots.size(); j++) begin
                        if (live_slots[j] == slot) begin
                            live_slots.delete(j);
                            break;
                        end
                    end
                    rep.st = ST_OK;
                end
            end
        end
        return rep;
    endfunction

    task automatic send_request(logic kind, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] addr,
                                logic typed, reply_t want);
        reply_t rep;
        start       <= 1'b1;
        i_kind      <= kind;
        i_req_size  <= size;
        i_free_addr <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        rep = predict_reply(kind, size, addr);
        pending_replies.push_back(typed ? want : rep);
    endtask

    task automatic idle_gap(bit allow);
        int r, n;
        r = $urandom_range(99);
        n = (r < 50) ? 0 : (r < 90) ? $urandom_range(3, 1) : $urandom_range(40, 8);
        if (allow && n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : check_reply
        reply_t want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: data_addr %0d status %0d", o_data_addr, o_status);
                mismatch_cnt++;
            end else begin
                want = pending_replies.pop_front();
                if (o_data_addr !== want.addr) begin
                    $error("data_addr: expected %0d, got %0d", want.addr, o_data_addr);
                    mismatch_cnt++;
                end
                if (o_granted_class !== want.cls) begin
                    $error("granted_class: expected %0d, got %0d", want.cls, o_granted_class);
                    mismatch_cnt++;
                end
                if (o_status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, o_status);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        int               seg, k, r, cls, slot;
        logic             kind;
        logic [REQ_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIRECTED; k++) begin
            idle_gap(1'b1);
            send_request(DIRECTED[k].kind, DIRECTED[k].size, DIRECTED[k].addr,
                         DIRECTED[k].typed, DIRECTED[k].want);
        end

        // mostly well-formed alloc/free traffic; segment 1 drains the heap with big blocks
        for (seg = 0; seg < N_SEGMENTS; seg++) begin
            for (k = 0; k < SEG_ITEMS; k++) begin
                idle_gap(seg != 3 && seg != 7);
                if ($urandom_range(99) < ALLOC_PCT[seg]) begin
                    kind = KIND_ALLOC;
                    addr = 18'($urandom());
                    r = $urandom_range(99);
                    if (r < 4) begin
                        size = '0;
                    end else if (r < 8) begin
                        size = $urandom();
                    end else if (r < 10) begin
                        size = $urandom_range(8000, 4089);
                    end else begin
                        cls = (seg == 1 && $urandom_range(9) != 0) ? TOP_CLASS
                                                                    : $urandom_range(7);
                        size = (cls == 0) ? $urandom_range(SLOT_BYTES - HDR_BYTES, 1)
                             : $urandom_range((SLOT_BYTES << cls) - HDR_BYTES,
                                              (SLOT_BYTES << (cls - 1)) - HDR_BYTES + 1);
                    end
                end else begin
                    kind = KIND_FREE;
                    size = $urandom();
                    r = $urandom_range(99);
                    if (r < 70 && live_slots.size() > 0) begin
                        slot = live_slots[$urandom_range(live_slots.size() - 1)];
                        addr = 18'(slot * SLOT_BYTES + HDR_BYTES);
                    end else if (r < 85 && block_starts.size() > 0) begin
                        slot = block_starts[$urandom_range(block_starts.size() - 1)];
                        addr = 18'(slot * SLOT_BYTES + HDR_BYTES);
                    end else begin
                        addr = 18'($urandom());
                        // never point inside a block of a taken chunk
                        if (addr >= HDR_BYTES && addr % SLOT_BYTES == HDR_BYTES
                            && (addr - HDR_BYTES) / SLOT_BYTES < chunks_taken * SLOTS_PER_CHUNK
                            && !hdr_known[(addr - HDR_BYTES) / SLOT_BYTES]) begin
                            addr[0] = 1'b1;
                        end
                    end
                end
                send_request(kind, size, addr, 1'b0, NONE);
            end
        end

        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
sv/spa_pkg.sv
sv/spa_size_class.sv
sv/spa_slot_mem.sv
sv/segregated_pool_allocator_unit.sv
tb/sv/segregated_pool_allocator_unit_tb.sv
